@@ hdl/tsnb_pkg.sv @@
// ----------------------------------------------------------------------------
// tsnb_pkg
// Shared types and constants of the texture sampler.
// ----------------------------------------------------------------------------
package tsnb_pkg;

    localparam int MaxWidth  = 256;
    localparam int MaxHeight = 256;
    localparam int XW        = $clog2(MaxWidth);
    localparam int YW        = $clog2(MaxHeight);
    localparam int SW        = XW + 1;
    localparam int AW        = XW + YW;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FILTER = 2'd2;

    localparam logic [17:0] ONE_Q16 = 18'h10000;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_READ,
        KIND_POINT,
        KIND_BLEND
    } kind_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        kind_t       kind;
        logic        zero;      // texel coordinates outside the active area
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic [16:0] fx;        // Q1.16 weights
        logic [16:0] fy;
        logic [63:0] texel;
    } cmd_t;

    localparam int CmdW = $bits(cmd_t);

endpackage

@@ hdl/tsnb_front.sv @@
// ----------------------------------------------------------------------------
// tsnb_front
// Classifies input beats and computes texel indices and blend weights.
// ----------------------------------------------------------------------------
module tsnb_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              op,
    input  logic [7:0]              tx,
    input  logic [7:0]              ty,
    input  logic signed [17:0]      cu,
    input  logic signed [17:0]      cv,
    input  logic [63:0]             texel,
    input  logic [tsnb_pkg::SW-1:0] w_in,
    input  logic [tsnb_pkg::SW-1:0] h_in,
    input  logic                    filt,
    output logic                    cmd_valid,
    input  logic                    cmd_ready,
    output tsnb_pkg::cmd_t          cmd
);

    // Stage 1: clamp, multiply by size minus one.
    logic              s1_valid_reg, s1_valid_next;
    logic [1:0]        s1_op_reg;
    logic              s1_in_reg;
    logic [7:0]        s1_tx_reg, s1_ty_reg;
    logic [26:0]       s1_px_reg, s1_py_reg;
    logic [63:0]       s1_tex_reg;
    logic [tsnb_pkg::SW-1:0] s1_wm1_reg, s1_hm1_reg;
    logic              s1_filt_reg;
    logic              s2_valid_reg, s2_valid_next;
    tsnb_pkg::cmd_t    s2_cmd_reg, s2_cmd_next;
    logic              s1_adv, s2_adv;

    logic [tsnb_pkg::SW-1:0] wc, hc;
    logic [16:0]       uc, vc;
    logic              ins;

    function automatic logic [16:0] clampc(input logic signed [17:0] c);
        if (c < 0) return 17'd0;
        if (c > $signed(tsnb_pkg::ONE_Q16)) return 17'h10000;
        return c[16:0];
    endfunction

    function automatic logic [tsnb_pkg::SW-1:0] clamps(input logic [tsnb_pkg::SW-1:0] s,
                                                      input logic [tsnb_pkg::SW-1:0] hi);
        if (s < tsnb_pkg::SW'(2)) return tsnb_pkg::SW'(2);
        if (s > hi) return hi;
        return s;
    endfunction

    always_comb begin
        wc  = clamps(w_in, tsnb_pkg::SW'(tsnb_pkg::MaxWidth));
        hc  = clamps(h_in, tsnb_pkg::SW'(tsnb_pkg::MaxHeight));
        uc  = clampc(cu);
        vc  = clampc(cv);
        ins = ({1'b0, tx} < wc) && ({1'b0, ty} < hc);
    end

    assign s2_adv   = !s2_valid_reg || cmd_ready;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    always_comb begin
        s1_valid_next = s1_adv ? in_valid : s1_valid_reg;
        s2_valid_next = s2_adv ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && in_valid) begin
            s1_op_reg   <= op;
            s1_in_reg   <= ins;
            s1_tx_reg   <= tx;
            s1_ty_reg   <= ty;
            s1_tex_reg  <= texel;
            s1_px_reg   <= 27'(uc * (wc - tsnb_pkg::SW'(1)));
            s1_py_reg   <= 27'(vc * (hc - tsnb_pkg::SW'(1)));
            s1_wm1_reg  <= wc - tsnb_pkg::SW'(1);
            s1_hm1_reg  <= hc - tsnb_pkg::SW'(1);
            s1_filt_reg <= filt;
        end
        if (s2_adv && s1_valid_reg) begin
            s2_cmd_reg <= s2_cmd_next;
        end
    end

    // Stage 2: integer index, edge pull-back, fractional weight.
    logic [10:0] ix, iy;
    always_comb begin
        ix = s1_px_reg[26:16];
        iy = s1_py_reg[26:16];
        s2_cmd_next       = '0;
        s2_cmd_next.texel = s1_tex_reg;
        s2_cmd_next.zero  = !s1_in_reg;
        s2_cmd_next.x     = s1_tx_reg[tsnb_pkg::XW-1:0];
        s2_cmd_next.y     = s1_ty_reg[tsnb_pkg::YW-1:0];
        case (s1_op_reg)
            tsnb_pkg::OP_WRITE: begin
                s2_cmd_next.kind = tsnb_pkg::KIND_WRITE;
            end
            tsnb_pkg::OP_READ: begin
                s2_cmd_next.kind = tsnb_pkg::KIND_READ;
            end
            default: begin
                if (!s1_filt_reg) begin
                    s2_cmd_next.kind = tsnb_pkg::KIND_POINT;
                end else begin
                    s2_cmd_next.kind = tsnb_pkg::KIND_BLEND;
                    if (ix >= 11'(s1_wm1_reg)) ix = 11'(s1_wm1_reg) - 11'd1;
                    if (iy >= 11'(s1_hm1_reg)) iy = 11'(s1_hm1_reg) - 11'd1;
                end
                s2_cmd_next.x  = ix[tsnb_pkg::XW-1:0];
                s2_cmd_next.y  = iy[tsnb_pkg::YW-1:0];
                s2_cmd_next.fx = 17'(s1_px_reg - {ix, 16'd0});
                s2_cmd_next.fy = 17'(s1_py_reg - {iy, 16'd0});
            end
        endcase
    end

    // Op 3 never reaches this unit, so every stage 2 entry is handed on.
    assign cmd_valid = s2_valid_reg;
    assign cmd       = s2_cmd_reg;

endmodule

@@ hdl/tsnb_queue.sv @@
// ----------------------------------------------------------------------------
// tsnb_queue
// Four-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tsnb_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  tsnb_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output tsnb_pkg::cmd_t out_cmd
);

    tsnb_pkg::cmd_t mem [4];
    logic [1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    logic push, pop;

    assign in_ready  = cnt_reg != 3'd4;
    assign out_valid = cnt_reg != 3'd0;
    assign out_cmd   = mem[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wp_next  = push ? wp_reg + 2'd1 : wp_reg;
        rp_next  = pop ? rp_reg + 2'd1 : rp_reg;
        cnt_next = cnt_reg + 3'(push) - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= in_cmd;
        end
    end

endmodule

@@ hdl/tsnb_back.sv @@
// ----------------------------------------------------------------------------
// tsnb_back
// Texel store in four parity banks and the bilinear blend pipeline.
// ----------------------------------------------------------------------------
module tsnb_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  tsnb_pkg::cmd_t cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [63:0]    out_data
);

    localparam int BD = (tsnb_pkg::MaxWidth / 2) * (tsnb_pkg::MaxHeight / 2);
    localparam int BA = tsnb_pkg::AW - 2;

    logic [63:0] bank0 [BD];
    logic [63:0] bank1 [BD];
    logic [63:0] bank2 [BD];
    logic [63:0] bank3 [BD];

    // Pipeline: F (fetch) -> M1 (row blend) -> M2 (column blend) -> out.
    logic f_valid_reg, f_valid_next, m1_valid_reg, m1_valid_next;
    logic m2_valid_reg, m2_valid_next, o_valid_reg, o_valid_next;
    logic f_adv, m1_adv, m2_adv, o_adv, take;

    tsnb_pkg::kind_t f_kind_reg;
    logic f_zero_reg, f_xo_reg, f_yo_reg;
    logic [16:0] f_fx_reg, f_fy_reg;
    logic [63:0] rd0_reg, rd1_reg, rd2_reg, rd3_reg;

    logic [tsnb_pkg::XW-1:0] x1;
    logic [tsnb_pkg::YW-1:0] y1;
    logic [tsnb_pkg::XW-2:0] ax0, ax1;
    logic [tsnb_pkg::YW-2:0] ay0, ay1;
    logic [BA-1:0] a0, a1, a2, a3;
    logic [1:0] wb;

    assign o_adv  = !o_valid_reg || out_ready;
    assign m2_adv = !m2_valid_reg || o_adv;
    assign m1_adv = !m1_valid_reg || m2_adv;
    assign f_adv  = !f_valid_reg || m1_adv;
    assign cmd_ready = f_adv;
    assign take   = cmd_valid && f_adv;

    // Bank b holds texels with x parity b[0] and y parity b[1].
    always_comb begin
        x1  = cmd.x + tsnb_pkg::XW'(1);
        y1  = cmd.y + tsnb_pkg::YW'(1);
        ax0 = cmd.x[tsnb_pkg::XW-1:1];
        ax1 = cmd.x[0] ? x1[tsnb_pkg::XW-1:1] : ax0;
        ay0 = cmd.y[tsnb_pkg::YW-1:1];
        ay1 = cmd.y[0] ? y1[tsnb_pkg::YW-1:1] : ay0;
        // bank with parity (p,q): row index uses ay1 where q differs from y parity
        a0 = {(cmd.y[0] ? ay1 : ay0), (cmd.x[0] ? ax1 : ax0)};
        a1 = {(cmd.y[0] ? ay1 : ay0), ax0};
        a2 = {ay0, (cmd.x[0] ? ax1 : ax0)};
        a3 = {ay0, ax0};
        wb = {cmd.y[0], cmd.x[0]};
    end

    always_ff @(posedge aclk) begin
        if (take && cmd.kind == tsnb_pkg::KIND_WRITE && !cmd.zero) begin
            case (wb)
                2'd0:    bank0[a3] <= cmd.texel;
                2'd1:    bank1[a3] <= cmd.texel;
                2'd2:    bank2[a3] <= cmd.texel;
                default: bank3[a3] <= cmd.texel;
            endcase
        end
        if (take) begin
            rd0_reg <= bank0[a0];
            rd1_reg <= bank1[a1];
            rd2_reg <= bank2[a2];
            rd3_reg <= bank3[a3];
            f_kind_reg <= cmd.kind;
            f_zero_reg <= cmd.zero;
            f_xo_reg   <= cmd.x[0];
            f_yo_reg   <= cmd.y[0];
            f_fx_reg   <= cmd.fx;
            f_fy_reg   <= cmd.fy;
        end
    end

    always_comb begin
        f_valid_next  = f_adv ? (cmd_valid && cmd.kind != tsnb_pkg::KIND_WRITE) : f_valid_reg;
        m1_valid_next = m1_adv ? f_valid_reg : m1_valid_reg;
        m2_valid_next = m2_adv ? m1_valid_reg : m2_valid_reg;
        o_valid_next  = o_adv ? m2_valid_reg : o_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg  <= 1'b0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else begin
            f_valid_reg  <= f_valid_next;
            m1_valid_reg <= m1_valid_next;
            m2_valid_reg <= m2_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    // Route banks to the four corners by base parity.
    logic [63:0] t00, t10, t01, t11, pt;
    always_comb begin
        case ({f_yo_reg, f_xo_reg})
            2'd0: begin
                t00 = rd0_reg; t10 = rd1_reg; t01 = rd2_reg; t11 = rd3_reg;
            end
            2'd1: begin
                t00 = rd1_reg; t10 = rd0_reg; t01 = rd3_reg; t11 = rd2_reg;
            end
            2'd2: begin
                t00 = rd2_reg; t10 = rd3_reg; t01 = rd0_reg; t11 = rd1_reg;
            end
            default: begin
                t00 = rd3_reg; t10 = rd2_reg; t01 = rd1_reg; t11 = rd0_reg;
            end
        endcase
        pt = (f_kind_reg == tsnb_pkg::KIND_READ && f_zero_reg) ? 64'd0 : t00;
    end

    function automatic logic [15:0] rnd(input logic signed [51:0] m);
        logic [51:0] r;
        if (m < 0) return 16'd0;
        r = (m + 52'sh80000000) >>> 32;
        if (r > 52'hFFFF) return 16'hFFFF;
        return r[15:0];
    endfunction

    logic signed [33:0] top_reg [4];
    logic signed [33:0] bot_reg [4];
    logic [16:0] m1_fy_reg;
    logic m1_blend_reg, m2_blend_reg;
    logic [63:0] m1_pt_reg, m2_pt_reg;
    logic signed [51:0] mix_reg [4];
    logic [63:0] o_data_reg;

    always_ff @(posedge aclk) begin
        if (m1_adv && f_valid_reg) begin
            m1_fy_reg    <= f_fy_reg;
            m1_blend_reg <= f_kind_reg == tsnb_pkg::KIND_BLEND;
            m1_pt_reg    <= pt;
        end
        if (m2_adv && m1_valid_reg) begin
            m2_blend_reg <= m1_blend_reg;
            m2_pt_reg    <= m1_pt_reg;
        end
        if (o_adv && m2_valid_reg) begin
            o_data_reg <= m2_blend_reg ? {rnd(mix_reg[3]), rnd(mix_reg[2]),
                                          rnd(mix_reg[1]), rnd(mix_reg[0])} : m2_pt_reg;
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_ch
        logic signed [17:0] a, b, d, e, fx;
        always_comb begin
            a  = {2'b0, t00[16*c +: 16]};
            b  = {2'b0, t10[16*c +: 16]};
            d  = {2'b0, t01[16*c +: 16]};
            e  = {2'b0, t11[16*c +: 16]};
            fx = {1'b0, f_fx_reg};
        end
        always_ff @(posedge aclk) begin
            if (m1_adv && f_valid_reg) begin
                top_reg[c] <= 34'({a, 16'd0}) + 34'((b - a) * fx);
                bot_reg[c] <= 34'({d, 16'd0}) + 34'((e - d) * fx);
            end
            if (m2_adv && m1_valid_reg) begin
                mix_reg[c] <= 52'({top_reg[c], 16'd0}) +
                              52'((bot_reg[c] - top_reg[c]) * $signed({1'b0, m1_fy_reg}));
            end
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

endmodule

@@ hdl/texture_sampler_nearest_bilinear.sv @@
// ----------------------------------------------------------------------------
// texture_sampler_nearest_bilinear
// RGBA texel store with a nearest and bilinear sampler.
// ----------------------------------------------------------------------------
// Usage. Beats enter on the s_axis channel; the operation code travels in
// s_axis_tuser, the texel coordinates, sample coordinates and colour in
// s_axis_tdata. Write beats store one texel and answer nothing; read and
// sample beats give exactly one result beat on m_axis, in order. Op code 3
// is dropped silently. Registers (width, height, filter mode) are written on
// the cfg channel; the user must write them only while the block is idle,
// which the block itself does not enforce. Throughput is one beat per cycle
// while the receiver accepts results: the four parity banks deliver the four
// neighbouring texels in one read. A beat passes two front stages, the
// command queue, the bank read, two blend multiplies and the output register.
// Reset clears all control state and the registers to width 256, height 256
// and bilinear filtering; the texture itself holds nothing defined until
// written. When the receiver stalls, the pipeline holds its contents and the
// four-entry queue fills before s_axis_tready drops.
// ----------------------------------------------------------------------------
module texture_sampler_nearest_bilinear (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: texel_x, texel_y, coord_u, coord_v, red, green, blue, alpha
    input  logic [119:0] s_axis_tdata,
    // tuser: op
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: out_red, out_green, out_blue, out_alpha
    output logic [63:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [8:0]   cfg_data
);

    logic [8:0] width_reg, height_reg;
    logic       filter_reg;
    logic       in_ok, fr_valid, fr_ready, q_valid, q_ready;
    tsnb_pkg::cmd_t fr_cmd, q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            filter_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                tsnb_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                tsnb_pkg::REG_HEIGHT: height_reg <= cfg_data;
                tsnb_pkg::REG_FILTER: filter_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Op 3 beats are swallowed at the port.
    logic op3, front_ready;
    assign op3           = s_axis_tuser == tsnb_pkg::OP_NONE;
    assign in_ok         = s_axis_tvalid && !op3;
    assign s_axis_tready = front_ready || op3;

    tsnb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_ok),
        .in_ready  (front_ready),
        .op        (s_axis_tuser),
        .tx        (s_axis_tdata[7:0]),
        .ty        (s_axis_tdata[15:8]),
        .cu        (s_axis_tdata[33:16]),
        .cv        (s_axis_tdata[51:34]),
        .texel     ({s_axis_tdata[115:100], s_axis_tdata[99:84],
                     s_axis_tdata[83:68], s_axis_tdata[67:52]}),
        .w_in      (width_reg),
        .h_in      (height_reg),
        .filt      (filter_reg),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd       (fr_cmd)
    );

    tsnb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_cmd    (fr_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    tsnb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // Reset puts the registers back to their defaults.
    assert property (@(posedge aclk) !aresetn |=> width_reg == 9'd256 && filter_reg)
        else $error("register reset value lost");

    // A result never appears in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid straight out of reset");

    // A command handed to the back end always carries a defined kind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |-> !$isunknown(q_cmd.kind))
        else $error("queue hands over an unknown command");

endmodule
